[src/tpi_pkg.sv]
// Shared types and constants for the triangle plane interpolator.
// Holds the item and result structs and the internal datapath widths.
// Depends on nothing.
`timescale 1ns / 1ps

package tpi_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    // Width of the plane terms D, Na and Nb.
    localparam int NW = 68;
    // Width of divider numerators, denominators and remainders.
    localparam int DIVW = 104;
    // Quotient bits produced by each divider.
    localparam int DIV_QBITS = 34;
    // Width of the squared terms in the unit normal search.
    localparam int NRMW = 128;
    // Width of the squared length of the normal.
    localparam int L2W = 64;
    // Bits of one normal component magnitude.
    localparam int NBITS = 31;

    typedef struct packed {
        logic signed [31:0] vertex_a_x;
        logic signed [31:0] vertex_a_y;
        logic signed [31:0] vertex_a_z;
        logic signed [31:0] vertex_b_x;
        logic signed [31:0] vertex_b_y;
        logic signed [31:0] vertex_b_z;
        logic signed [31:0] vertex_c_x;
        logic signed [31:0] vertex_c_y;
        logic signed [31:0] vertex_c_z;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interp_z;
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic [30:0]        normal_z;
        logic               valid_res;
    } out_item_t;

endpackage

[src/tpi_div.sv]
// Pipelined signed divider that retires one quotient bit per stage.
// Flags quotients that do not fit in QBITS bits; uses tpi_pkg widths.
// Depends on tpi_pkg.
`timescale 1ns / 1ps

module tpi_div
    import tpi_pkg::*;
#(
    parameter int QBITS = DIV_QBITS
)
(
    input  logic                   clk,
    input  logic signed [DIVW-1:0] num,
    input  logic signed [DIVW-1:0] den,
    output logic [QBITS-1:0]       quo,
    output logic                   ovf,
    output logic                   neg
);

    localparam int EW = DIVW + QBITS;

    logic [DIVW-1:0] nabs_reg;
    logic [DIVW-1:0] dabs_reg;
    logic            nega_reg;
    logic [DIVW-1:0] nabs_next;
    logic [DIVW-1:0] dabs_next;
    logic            ovf_next;

    logic [DIVW-1:0]  rem_reg [QBITS+1];
    logic [DIVW-1:0]  dv_reg  [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             ovf_reg [QBITS+1];
    logic             neg_reg [QBITS+1];

    assign nabs_next = num[DIVW-1] ? ('0 - num) : num;
    assign dabs_next = den[DIVW-1] ? ('0 - den) : den;
    assign ovf_next  = EW'(nabs_reg) >= (EW'(dabs_reg) << QBITS);

    always_ff @(posedge clk)
    begin
        nabs_reg   <= nabs_next;
        dabs_reg   <= dabs_next;
        nega_reg   <= num[DIVW-1] ^ den[DIVW-1];
        rem_reg[0] <= nabs_reg;
        dv_reg[0]  <= dabs_reg;
        q_reg[0]   <= '0;
        ovf_reg[0] <= ovf_next;
        neg_reg[0] <= nega_reg;
    end

    for (genvar s = 0; s < QBITS; s++)
    begin : g_step
        localparam int B = QBITS - 1 - s;
        logic [EW-1:0] trial;
        logic          take;

        assign trial = EW'(dv_reg[s]) << B;
        assign take  = EW'(rem_reg[s]) >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= take ? (rem_reg[s] - trial[DIVW-1:0]) : rem_reg[s];
            q_reg[s+1]   <= take ? (q_reg[s] | (QBITS'(1) << B)) : q_reg[s];
            dv_reg[s+1]  <= dv_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
            neg_reg[s+1] <= neg_reg[s];
        end
    end

    assign quo = q_reg[QBITS];
    assign ovf = ovf_reg[QBITS];
    assign neg = neg_reg[QBITS];

endmodule

[src/tpi_norm.sv]
// Pipelined search for one unit normal component, one result bit per stage.
// Finds the largest n with n*n*l2 <= m2 using shifted adds only.
// Depends on tpi_pkg.
`timescale 1ns / 1ps

module tpi_norm
    import tpi_pkg::*;
(
    input  logic             clk,
    input  logic [L2W-1:0]   l2,
    input  logic [NRMW-1:0]  m2,
    output logic [NBITS-1:0] n
);

    logic [NRMW-1:0]  p_reg  [NBITS+1];
    logic [NRMW-1:0]  qa_reg [NBITS+1];
    logic [L2W-1:0]   l2_reg [NBITS+1];
    logic [NRMW-1:0]  m2_reg [NBITS+1];
    logic [NBITS-1:0] n_reg  [NBITS+1];

    always_ff @(posedge clk)
    begin
        p_reg[0]  <= '0;
        qa_reg[0] <= '0;
        n_reg[0]  <= '0;
        l2_reg[0] <= l2;
        m2_reg[0] <= m2;
    end

    // With P = n*n*l2 and Q = n*l2, setting bit k adds 2^(k+1)*Q + 4^k*l2 to P.
    for (genvar s = 0; s < NBITS; s++)
    begin : g_step
        localparam int K = NBITS - 1 - s;
        logic [NRMW-1:0] l2w;
        logic [NRMW-1:0] cand;
        logic            take;

        assign l2w  = NRMW'(l2_reg[s]);
        assign cand = p_reg[s] + (qa_reg[s] << (K + 1)) + (l2w << (2 * K));
        assign take = cand <= m2_reg[s];

        always_ff @(posedge clk)
        begin
            p_reg[s+1]  <= take ? cand : p_reg[s];
            qa_reg[s+1] <= take ? (qa_reg[s] + (l2w << K)) : qa_reg[s];
            n_reg[s+1]  <= take ? (n_reg[s] | (NBITS'(1) << K)) : n_reg[s];
            l2_reg[s+1] <= l2_reg[s];
            m2_reg[s+1] <= m2_reg[s];
        end
    end

    assign n = n_reg[NBITS];

endmodule

[src/triangle_plane_interpolator_top.sv]
// Top level of the triangle plane interpolator.
// Uses tpi_pkg, the tpi_div dividers and the tpi_norm normal lanes.
//
// A transaction enters when start is high and busy is low. busy is always low:
// the datapath is a fixed pipeline that takes one transaction in every cycle.
// Each transaction carries three vertices and a query point in signed fixed
// point with FRAC_BITS fraction bits. Exactly one result comes back per
// transaction, in order, on result while done is high for one cycle.
// The pipeline holds the 36 stages of the slope and height dividers, which
// retire one quotient bit per stage, the 32 stages of the normal search,
// which retire one normal bit per stage, and the stages of products, sums
// and saturation.
// Throughput is one transaction per cycle.
// The receiver cannot stall the block, so results are never held.
// Reset clears the valid bits of every stage; no result is produced for
// anything in flight when reset is asserted.
`timescale 1ns / 1ps

module triangle_plane_interpolator_top
    import tpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      done,
    output out_item_t result
);

    localparam int LDIV  = DIV_QBITS + 2;
    localparam int LNORM = NBITS + 1;
    localparam int HW    = DIV_QBITS + 3;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [31:0] za;
    } side_t;

    typedef struct packed {
        logic               vld;
        logic               dz;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [31:0] iz;
    } side2_t;

    function automatic logic signed [31:0] sat_slope(input logic [DIV_QBITS-1:0] q,
                                                     input logic ovf,
                                                     input logic neg);
        logic big;
        logic signed [31:0] r;
        big = ovf || (q[DIV_QBITS-1:31] != '0);
        if (neg)
        begin
            if (ovf || (q > (DIV_QBITS'(1) << 31)))
                r = 32'sh8000_0000;
            else
                r = 32'd0 - q[31:0];
        end
        else
        begin
            r = big ? 32'sh7fff_ffff : $signed({1'b0, q[30:0]});
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // Stage 1: coordinate differences.
    logic               s1_vld_reg;
    logic signed [32:0] xab_reg, ybc_reg, xbc_reg, yab_reg, yca_reg, xca_reg;
    logic signed [32:0] qxa_reg, qya_reg;
    logic signed [31:0] za1_reg, zb1_reg, zc1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        xab_reg <= {item.vertex_a_x[31], item.vertex_a_x} - {item.vertex_b_x[31], item.vertex_b_x};
        ybc_reg <= {item.vertex_b_y[31], item.vertex_b_y} - {item.vertex_c_y[31], item.vertex_c_y};
        xbc_reg <= {item.vertex_b_x[31], item.vertex_b_x} - {item.vertex_c_x[31], item.vertex_c_x};
        yab_reg <= {item.vertex_a_y[31], item.vertex_a_y} - {item.vertex_b_y[31], item.vertex_b_y};
        yca_reg <= {item.vertex_c_y[31], item.vertex_c_y} - {item.vertex_a_y[31], item.vertex_a_y};
        xca_reg <= {item.vertex_c_x[31], item.vertex_c_x} - {item.vertex_a_x[31], item.vertex_a_x};
        qxa_reg <= {item.query_x[31], item.query_x} - {item.vertex_a_x[31], item.vertex_a_x};
        qya_reg <= {item.query_y[31], item.query_y} - {item.vertex_a_y[31], item.vertex_a_y};
        za1_reg <= item.vertex_a_z;
        zb1_reg <= item.vertex_b_z;
        zc1_reg <= item.vertex_c_z;
    end

    // Stage 2: products.
    logic               s2_vld_reg;
    logic signed [65:0] pd1_reg, pd2_reg, pa1_reg, pa2_reg, pa3_reg;
    logic signed [65:0] pb1_reg, pb2_reg, pb3_reg;
    logic signed [32:0] qxa2_reg, qya2_reg;
    logic signed [31:0] za2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        pd1_reg  <= xab_reg * ybc_reg;
        pd2_reg  <= xbc_reg * yab_reg;
        pa1_reg  <= za1_reg * ybc_reg;
        pa2_reg  <= zb1_reg * yca_reg;
        pa3_reg  <= zc1_reg * yab_reg;
        pb1_reg  <= za1_reg * xbc_reg;
        pb2_reg  <= zb1_reg * xca_reg;
        pb3_reg  <= zc1_reg * xab_reg;
        qxa2_reg <= qxa_reg;
        qya2_reg <= qya_reg;
        za2_reg  <= za1_reg;
    end

    // Stage 3: plane terms.
    logic               s3_vld_reg;
    logic signed [NW-1:0] d3_reg, na3_reg, nb3_reg;
    logic signed [NW-1:0] d3_next, na3_next, nb3_next;
    logic signed [32:0] qxa3_reg, qya3_reg;
    logic signed [31:0] za3_reg;

    assign d3_next  = NW'(pd1_reg) - NW'(pd2_reg);
    assign na3_next = NW'(pa1_reg) + NW'(pa2_reg) + NW'(pa3_reg);
    assign nb3_next = NW'(0) - (NW'(pb1_reg) + NW'(pb2_reg) + NW'(pb3_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        d3_reg   <= d3_next;
        na3_reg  <= na3_next;
        nb3_reg  <= nb3_next;
        qxa3_reg <= qxa2_reg;
        qya3_reg <= qya2_reg;
        za3_reg  <= za2_reg;
    end

    // Stage 4: split products for the height numerator.
    logic               s4_vld_reg;
    logic               dz4_reg;
    logic signed [67:0] hx_reg, hy_reg, lx_reg, ly_reg;
    logic signed [NW-1:0] d4_reg, na4_reg, nb4_reg;
    logic signed [31:0] za4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        hx_reg  <= $signed(na3_reg[NW-1:34]) * qxa3_reg;
        hy_reg  <= $signed(nb3_reg[NW-1:34]) * qya3_reg;
        lx_reg  <= $signed({1'b0, na3_reg[33:0]}) * qxa3_reg;
        ly_reg  <= $signed({1'b0, nb3_reg[33:0]}) * qya3_reg;
        dz4_reg <= (d3_reg == '0);
        d4_reg  <= d3_reg;
        na4_reg <= na3_reg;
        nb4_reg <= nb3_reg;
        za4_reg <= za3_reg;
    end

    // Stage 5: divider operands.
    logic signed [DIVW-1:0] zn_next, nas_next, nbs_next;
    logic signed [DIVW-1:0] zn_reg, nas_reg, nbs_reg, den_reg;
    side_t                  s5_reg;

    assign zn_next  = ((DIVW'(hx_reg) + DIVW'(hy_reg)) <<< 34) + DIVW'(lx_reg) + DIVW'(ly_reg);
    assign nas_next = DIVW'(na4_reg) <<< FRAC_BITS;
    assign nbs_next = DIVW'(nb4_reg) <<< FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_reg <= '0;
        else
            s5_reg <= '{vld: s4_vld_reg, dz: dz4_reg, za: za4_reg};
    end

    always_ff @(posedge clk)
    begin
        zn_reg  <= zn_next;
        nas_reg <= nas_next;
        nbs_reg <= nbs_next;
        den_reg <= DIVW'(d4_reg);
    end

    logic [DIV_QBITS-1:0] qa, qb, qz;
    logic                 ova, ovb, ovz, nga, ngb, ngz;

    tpi_div #(.QBITS(DIV_QBITS)) u_div_a (
        .clk (clk),
        .num (nas_reg),
        .den (den_reg),
        .quo (qa),
        .ovf (ova),
        .neg (nga)
    );

    tpi_div #(.QBITS(DIV_QBITS)) u_div_b (
        .clk (clk),
        .num (nbs_reg),
        .den (den_reg),
        .quo (qb),
        .ovf (ovb),
        .neg (ngb)
    );

    tpi_div #(.QBITS(DIV_QBITS)) u_div_z (
        .clk (clk),
        .num (zn_reg),
        .den (den_reg),
        .quo (qz),
        .ovf (ovz),
        .neg (ngz)
    );

    side_t side_reg [LDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LDIV; i++)
                side_reg[i] <= '0;
        end
        else
        begin
            side_reg[0] <= s5_reg;
            for (int i = 1; i < LDIV; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Stage 6: saturated slopes and height.
    logic [DIV_QBITS:0]   qq;
    logic signed [HW-1:0] qs;
    logic signed [HW-1:0] hsum;
    logic signed [31:0]   iz_next;
    side2_t               s6_reg;

    always_comb
    begin
        qq = ovz ? ((DIV_QBITS + 1)'(1) << DIV_QBITS) : {1'b0, qz};
        qs = $signed({2'b00, qq});
        if (ngz)
            qs = HW'(0) - qs;
        hsum = HW'(side_reg[LDIV-1].za) + qs;
        if ((hsum[HW-1:31] == '0) || (hsum[HW-1:31] == '1))
            iz_next = hsum[31:0];
        else
            iz_next = hsum[HW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_reg <= '0;
        else
            s6_reg <= '{vld: side_reg[LDIV-1].vld, dz: side_reg[LDIV-1].dz,
                        sa: sat_slope(qa, ova, nga), sb: sat_slope(qb, ovb, ngb),
                        iz: iz_next};
    end

    // Stage 7: squared slope magnitudes.
    logic [31:0] ma_next, mb_next;
    logic [63:0] ma2_reg, mb2_reg;
    side2_t      s7_reg;

    assign ma_next = s6_reg.sa[31] ? (32'd0 - s6_reg.sa) : s6_reg.sa;
    assign mb_next = s6_reg.sb[31] ? (32'd0 - s6_reg.sb) : s6_reg.sb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_reg <= '0;
        else
            s7_reg <= s6_reg;
    end

    always_ff @(posedge clk)
    begin
        ma2_reg <= ma_next * ma_next;
        mb2_reg <= mb_next * mb_next;
    end

    // Stage 8: squared length and squared scaled magnitudes.
    logic [L2W-1:0]  l2_reg;
    logic [NRMW-1:0] m2x_reg, m2y_reg, m2z_reg;
    side2_t          s8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_reg <= '0;
        else
            s8_reg <= s7_reg;
    end

    always_ff @(posedge clk)
    begin
        l2_reg  <= ma2_reg + mb2_reg + (L2W'(1) << (2 * FRAC_BITS));
        m2x_reg <= NRMW'(ma2_reg) << 60;
        m2y_reg <= NRMW'(mb2_reg) << 60;
        m2z_reg <= NRMW'(1) << (2 * FRAC_BITS + 60);
    end

    logic [NBITS-1:0] nx, ny, nz;

    tpi_norm u_norm_x (
        .clk (clk),
        .l2  (l2_reg),
        .m2  (m2x_reg),
        .n   (nx)
    );

    tpi_norm u_norm_y (
        .clk (clk),
        .l2  (l2_reg),
        .m2  (m2y_reg),
        .n   (ny)
    );

    tpi_norm u_norm_z (
        .clk (clk),
        .l2  (l2_reg),
        .m2  (m2z_reg),
        .n   (nz)
    );

    side2_t side2_reg [LNORM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LNORM; i++)
                side2_reg[i] <= '0;
        end
        else
        begin
            side2_reg[0] <= s8_reg;
            for (int i = 1; i < LNORM; i++)
                side2_reg[i] <= side2_reg[i-1];
        end
    end

    // Final stage: signs, degenerate masking and the result register.
    side2_t    fin;
    out_item_t result_next;
    logic      done_reg;
    out_item_t result_reg;

    always_comb
    begin
        fin = side2_reg[LNORM-1];
        result_next = '0;
        if (!fin.dz)
        begin
            result_next.interp_z  = fin.iz;
            result_next.slope_x   = fin.sa;
            result_next.slope_y   = fin.sb;
            result_next.normal_x  = (!fin.sa[31] && (fin.sa != 0)) ?
                                    (32'd0 - {1'b0, nx}) : {1'b0, nx};
            result_next.normal_y  = (!fin.sb[31] && (fin.sb != 0)) ?
                                    (32'd0 - {1'b0, ny}) : {1'b0, ny};
            result_next.normal_z  = nz;
            result_next.valid_res = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin.vld;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[test/tpi_checker.sv]
// Checker for the triangle plane interpolator: predicts each result and compares it.
// Watches the command and result channels of the block; uses tpi_pkg for the payload types.
`timescale 1ns / 1ps

module tpi_checker
    import tpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  item,
    input  logic      done,
    input  out_item_t result,
    output int        errors,
    output int        outstanding
);

    typedef logic signed [127:0] wide_t;

    localparam logic [127:0] HEIGHT_CLAMP = 128'd1 << 40;

    out_item_t planes_due[$];

    function automatic logic signed [63:0] clamped_quotient(input wide_t num, input wide_t den);
        logic [127:0] mag_num;
        logic [127:0] mag_den;
        logic [127:0] q;
        logic signed [63:0] m;
        mag_num = (num < 0) ? -num : num;
        mag_den = (den < 0) ? -den : den;
        q = mag_num / mag_den;
        m = (q > HEIGHT_CLAMP) ? 64'sd1 <<< 40 : $signed(q[63:0]);
        return ((num < 0) != (den < 0)) ? -m : m;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned unit_component(input longint unsigned m,
                                                       input longint unsigned len2);
        logic [127:0] scaled;
        logic [127:0] limit;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        scaled = {64'd0, m} << 30;
        limit = scaled * scaled;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (({64'd0, mid * mid} * {64'd0, len2}) <= limit)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic out_item_t predict_plane(input in_item_t it);
        out_item_t r;
        longint xa, ya, za, xb, yb, zb, xc, yc, zc, qx, qy;
        wide_t det, num_a, num_b, height_num;
        logic signed [31:0] sa, sb;
        longint unsigned ma, mb, len2, nx, ny, nz;
        xa = it.vertex_a_x;
        ya = it.vertex_a_y;
        za = it.vertex_a_z;
        xb = it.vertex_b_x;
        yb = it.vertex_b_y;
        zb = it.vertex_b_z;
        xc = it.vertex_c_x;
        yc = it.vertex_c_y;
        zc = it.vertex_c_z;
        qx = it.query_x;
        qy = it.query_y;
        r = '0;
        det = wide_t'(xa - xb) * wide_t'(yb - yc) - wide_t'(xb - xc) * wide_t'(ya - yb);
        if (det == 0)
            return r;
        num_a = wide_t'(za) * wide_t'(yb - yc) + wide_t'(zb) * wide_t'(yc - ya)
              + wide_t'(zc) * wide_t'(ya - yb);
        num_b = -(wide_t'(za) * wide_t'(xb - xc) + wide_t'(zb) * wide_t'(xc - xa)
              + wide_t'(zc) * wide_t'(xa - xb));
        sa = clip32(clamped_quotient(num_a <<< FRAC_BITS, det));
        sb = clip32(clamped_quotient(num_b <<< FRAC_BITS, det));
        height_num = num_a * wide_t'(qx - xa) + num_b * wide_t'(qy - ya);
        r.interp_z = clip32(za + clamped_quotient(height_num, det));
        r.slope_x = sa;
        r.slope_y = sb;
        ma = (sa < 0) ? -longint'(sa) : longint'(sa);
        mb = (sb < 0) ? -longint'(sb) : longint'(sb);
        len2 = ma * ma + mb * mb + (64'd1 << (2 * FRAC_BITS));
        nx = unit_component(ma, len2);
        ny = unit_component(mb, len2);
        nz = unit_component(64'd1 << FRAC_BITS, len2);
        r.normal_x = (sa > 0) ? -nx[31:0] : nx[31:0];
        r.normal_y = (sb > 0) ? -ny[31:0] : ny[31:0];
        r.normal_z = nz[30:0];
        r.valid_res = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n) begin
            planes_due.delete();
            errors <= 0;
            outstanding <= 0;
        end else begin
            if (start && !busy)
                planes_due.push_back(predict_plane(item));
            if (done) begin
                if (planes_due.size() == 0) begin
                    if (errors < 10)
                        $display("ERROR: result with no transaction pending: %p", result);
                    errors <= errors + 1;
                end else begin
                    exp_r = planes_due.pop_front();
                    if (result.interp_z !== exp_r.interp_z || result.slope_x !== exp_r.slope_x
                        || result.slope_y !== exp_r.slope_y
                        || result.normal_x !== exp_r.normal_x
                        || result.normal_y !== exp_r.normal_y
                        || result.normal_z !== exp_r.normal_z
                        || result.valid_res !== exp_r.valid_res) begin
                        if (errors < 10)
                            $display("ERROR: mismatch expected %p actual %p", exp_r, result);
                        errors <= errors + 1;
                    end
                end
            end
            outstanding <= planes_due.size();
        end
    end

endmodule

[test/tb.sv]
// Testbench top for the triangle plane interpolator: drives directed and random
// triangles with random idle gaps and gives the verdict. Uses tpi_pkg and tpi_checker.
`timescale 1ns / 1ps

module tb
    import tpi_pkg::*;
();

    localparam int STALL_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      done;
    out_item_t result;
    int        errors;
    int        outstanding;
    int        idle_pct;
    int        quiet_cycles = 0;

    triangle_plane_interpolator_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .done(done), .result(result)
    );

    tpi_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .errors(errors), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_triangle(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic signed [31:0] coord(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
            2: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic in_item_t random_triangle();
        in_item_t it;
        int mode;
        int k;
        mode = $urandom_range(9);
        it.vertex_a_x = coord(mode < 3 ? 0 : (mode < 8 ? 1 : $urandom_range(3)));
        it.vertex_a_y = coord(mode < 3 ? 0 : (mode < 8 ? 1 : $urandom_range(3)));
        it.vertex_b_x = coord(mode < 3 ? 0 : (mode < 8 ? 1 : $urandom_range(3)));
        it.vertex_b_y = coord(mode < 3 ? 0 : (mode < 8 ? 1 : $urandom_range(3)));
        it.vertex_c_x = coord(mode < 3 ? 0 : (mode < 8 ? 1 : $urandom_range(3)));
        it.vertex_c_y = coord(mode < 3 ? 0 : (mode < 8 ? 1 : $urandom_range(3)));
        it.vertex_a_z = coord($urandom_range(3));
        it.vertex_b_z = coord($urandom_range(3));
        it.vertex_c_z = coord($urandom_range(3));
        it.query_x = coord($urandom_range(3));
        it.query_y = coord($urandom_range(3));
        if (mode == 7)
        begin
            // Collinear vertices: the third lies on the line through the first two.
            k = $urandom_range(6) - 3;
            it.vertex_c_x = it.vertex_a_x + k * (it.vertex_b_x - it.vertex_a_x);
            it.vertex_c_y = it.vertex_a_y + k * (it.vertex_b_y - it.vertex_a_y);
        end
        return it;
    endfunction

    function automatic in_item_t make_triangle(input int ax, ay, az, bx, by, bz,
                                               input int cx, cy, cz, qx, qy);
        in_item_t it;
        it = '{ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy};
        return it;
    endfunction

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_triangle('0);
        send_triangle('1);
        send_triangle(make_triangle(0, 0, 0, 65536, 0, 65536, 0, 65536, 131072, 32768, 32768));
        send_triangle(make_triangle(0, 0, 196608, 65536, 0, 196608, 0, 65536, 196608,
                                    -65536, 65536));
        send_triangle(make_triangle(0, 0, 0, 1, 0, 32'h7fffffff, 0, 1, 32'h80000000, 5, 5));
        send_triangle(make_triangle(0, 0, 0, 1, 0, -65536, 0, 1, 65536, 1000, -1000));
        send_triangle(make_triangle(0, 0, 0, 1, 0, 1, 0, 1, 1, 32'h7fffffff, 32'h7fffffff));
        send_triangle(make_triangle(0, 0, 0, 1, 0, -1, 0, 1, -1, 32'h7fffffff, 32'h7fffffff));
        send_triangle(make_triangle(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                    32'h80000000, 32'h7fffffff, 0, 0, 0));
        send_triangle(make_triangle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    32'h80000000, 32'h7fffffff, 32'h80000000,
                                    32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                    32'h80000000, 32'h80000000));
        send_triangle(make_triangle(0, 0, 5, 65536, 65536, 6, 131072, 131072, 7, 0, 0));
        send_triangle(make_triangle(7, 7, 1, 7, 7, 2, 9, 3, 3, 0, 0));
        send_triangle(make_triangle(1, 2, 3, 1, 2, 3, 1, 2, 3, 4, 5));
        send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 12345, -999));
        send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 32768, 1, 32'h40000000, 0, 65536));
        send_triangle(make_triangle(-65536, -65536, -100, 65536, -65536, 100,
                                    0, 65536, -50, 0, 0));

        for (i = 0; i < 700; i++)
        begin
            idle_pct = (i < 240) ? 23 : ((i < 460) ? 63 : 0);
            send_triangle(random_triangle());
        end
        start <= 1'b0;

        while (outstanding != 0 || done)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
